@@ rtl/core/bfbb_pkg.sv @@
// Package for the BMP foreground bounding box block.
// Holds sizes, header offsets, the parser phase type and the queue word type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfbb_pkg;

    localparam int unsigned MAX_DIM       = 4096;
    localparam int unsigned HEADER_BYTES  = 54;
    localparam int unsigned WIDTH_OFFSET  = 18;
    localparam int unsigned HEIGHT_OFFSET = 22;
    localparam logic [7:0]  TOL_RESET     = 8'd10;

    localparam int unsigned POS_W  = 12;
    localparam int unsigned DIM_W  = 13;
    localparam int unsigned PIX_W  = 24;
    localparam int unsigned HCNT_W = $clog2(HEADER_BYTES + 1);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);
    localparam int unsigned QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_PIXELS = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    // One queue word: a finished pixel, or a bad-header error.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             first;
        logic             last;
        logic             err;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/core/bfbb_front.sv @@
// Front end: accepts file bytes, parses the header, assembles pixels,
// tracks column, row and row padding. Depends on bfbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbb_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic            i_start_of_file,
    input  wire logic            i_full,
    output logic                 o_push,
    output bfbb_pkg::t_entry     o_entry
);

    bfbb_pkg::t_phase               r_phase, n_phase, e_phase;
    logic [bfbb_pkg::HCNT_W-1:0]    r_hcnt, n_hcnt, e_hcnt, k_w, k_h;
    logic [31:0]                    r_w, n_w, e_w;
    logic [31:0]                    r_h, n_h, e_h;
    logic [bfbb_pkg::POS_W-1:0]     r_col, n_col, e_col;
    logic [bfbb_pkg::POS_W-1:0]     r_row, n_row, e_row;
    logic [1:0]                     r_bip, n_bip, e_bip;
    logic [15:0]                    r_part, n_part, e_part;
    logic [1:0]                     r_pad, n_pad, e_pad;
    logic [bfbb_pkg::DIM_W-1:0]     col_inc, row_inc;
    logic                           accept, w_ok, h_ok;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        e_phase = i_start_of_file ? bfbb_pkg::PH_HEADER : r_phase;
        e_hcnt  = i_start_of_file ? '0 : r_hcnt;
        e_w     = i_start_of_file ? '0 : r_w;
        e_h     = i_start_of_file ? '0 : r_h;
        e_col   = i_start_of_file ? '0 : r_col;
        e_row   = i_start_of_file ? '0 : r_row;
        e_bip   = i_start_of_file ? '0 : r_bip;
        e_part  = i_start_of_file ? '0 : r_part;
        e_pad   = i_start_of_file ? '0 : r_pad;

        n_phase = e_phase;
        n_hcnt  = e_hcnt;
        n_w     = e_w;
        n_h     = e_h;
        n_col   = e_col;
        n_row   = e_row;
        n_bip   = e_bip;
        n_part  = e_part;
        n_pad   = e_pad;

        k_w     = e_hcnt - bfbb_pkg::HCNT_W'(bfbb_pkg::WIDTH_OFFSET);
        k_h     = e_hcnt - bfbb_pkg::HCNT_W'(bfbb_pkg::HEIGHT_OFFSET);
        col_inc = {1'b0, e_col} + 1'b1;
        row_inc = {1'b0, e_row} + 1'b1;
        w_ok    = 1'b0;
        h_ok    = 1'b0;

        o_push        = 1'b0;
        o_entry       = '0;
        o_entry.pix   = {e_part[7:0], e_part[15:8], i_data_byte};
        o_entry.col   = e_col;
        o_entry.row   = e_row;
        o_entry.first = (e_col == '0) && (e_row == '0);
        o_entry.width  = e_w[bfbb_pkg::DIM_W-1:0];
        o_entry.height = e_h[bfbb_pkg::DIM_W-1:0];

        case (e_phase)
            bfbb_pkg::PH_HEADER: begin
                if (e_hcnt >= bfbb_pkg::HCNT_W'(bfbb_pkg::WIDTH_OFFSET) &&
                    e_hcnt <  bfbb_pkg::HCNT_W'(bfbb_pkg::WIDTH_OFFSET + 4)) begin
                    n_w[{k_w[1:0], 3'b000} +: 8] = i_data_byte;
                end else if (e_hcnt >= bfbb_pkg::HCNT_W'(bfbb_pkg::HEIGHT_OFFSET) &&
                    e_hcnt <  bfbb_pkg::HCNT_W'(bfbb_pkg::HEIGHT_OFFSET + 4)) begin
                    n_h[{k_h[1:0], 3'b000} +: 8] = i_data_byte;
                end
                n_hcnt = e_hcnt + 1'b1;
                w_ok = (n_w != '0) && (n_w <= 32'(bfbb_pkg::MAX_DIM));
                h_ok = (n_h != '0) && (n_h <= 32'(bfbb_pkg::MAX_DIM));
                if (n_hcnt >= bfbb_pkg::HCNT_W'(bfbb_pkg::HEADER_BYTES)) begin
                    if (!w_ok || !h_ok) begin
                        o_push      = 1'b1;
                        o_entry     = '0;
                        o_entry.err = 1'b1;
                        n_phase     = bfbb_pkg::PH_DONE;
                    end else begin
                        n_phase = bfbb_pkg::PH_PIXELS;
                    end
                end
            end
            bfbb_pkg::PH_PIXELS: begin
                if (e_pad != '0) begin
                    n_pad = e_pad - 1'b1;
                    if (n_pad == '0) begin
                        n_col = '0;
                        n_row = row_inc[bfbb_pkg::POS_W-1:0];
                    end
                end else if (e_bip < 2'd2) begin
                    n_part[{e_bip[0], 3'b000} +: 8] = i_data_byte;
                    n_bip = e_bip + 1'b1;
                end else begin
                    o_push = 1'b1;
                    n_bip  = '0;
                    n_part = '0;
                    n_col  = col_inc[bfbb_pkg::POS_W-1:0];
                    if (col_inc >= e_w[bfbb_pkg::DIM_W-1:0]) begin
                        // pad bytes per row = width mod 4 for 3-byte pixels
                        if (e_w[1:0] != '0 && row_inc < e_h[bfbb_pkg::DIM_W-1:0]) begin
                            n_pad = e_w[1:0];
                        end else begin
                            n_col = '0;
                            n_row = row_inc[bfbb_pkg::POS_W-1:0];
                            if (row_inc >= e_h[bfbb_pkg::DIM_W-1:0]) begin
                                o_entry.last = 1'b1;
                                n_phase      = bfbb_pkg::PH_DONE;
                            end
                        end
                    end
                end
            end
            bfbb_pkg::PH_DONE: begin
            end
            default: begin
                n_phase = bfbb_pkg::PH_HEADER;
            end
        endcase

        o_push = o_push && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bfbb_pkg::PH_HEADER;
            r_hcnt  <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_bip   <= '0;
            r_part  <= '0;
            r_pad   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_w     <= n_w;
            r_h     <= n_h;
            r_col   <= n_col;
            r_row   <= n_row;
            r_bip   <= n_bip;
            r_part  <= n_part;
            r_pad   <= n_pad;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bfbb_queue.sv @@
// Short first-in first-out queue of pixel words between front and back.
// Depends on bfbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbb_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bfbb_pkg::t_entry i_entry,
    output logic                  o_full,
    output logic                  o_valid,
    output bfbb_pkg::t_entry      o_entry,
    input  wire logic             i_pop
);

    bfbb_pkg::t_entry            r_mem [bfbb_pkg::QDEPTH];
    logic [bfbb_pkg::QAW-1:0]    r_wr, r_rd;
    logic [bfbb_pkg::QCW-1:0]    r_cnt;

    assign o_full  = (r_cnt == bfbb_pkg::QCW'(bfbb_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bfbb_back.sv @@
// Back end: background test against tolerance, bounding box update and
// the result output register. Depends on bfbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbb_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tolerance_we,
    input  wire logic [7:0]                    i_tolerance,
    input  wire logic                          i_q_valid,
    input  wire bfbb_pkg::t_entry              i_q_entry,
    output logic                               o_pop,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_status,
    output logic                               o_found,
    output logic [bfbb_pkg::POS_W-1:0]         o_x_min,
    output logic [bfbb_pkg::POS_W-1:0]         o_x_max,
    output logic [bfbb_pkg::POS_W-1:0]         o_y_min,
    output logic [bfbb_pkg::POS_W-1:0]         o_y_max,
    output logic [bfbb_pkg::DIM_W-1:0]         o_image_width,
    output logic [bfbb_pkg::DIM_W-1:0]         o_image_height,
    output logic [bfbb_pkg::PIX_W-1:0]         o_background_color
);

    logic [7:0]                  r_tol;
    logic [bfbb_pkg::PIX_W-1:0]  r_bg, n_bg;
    logic [bfbb_pkg::POS_W-1:0]  r_xmin, r_xmax, r_ymin, r_ymax;
    logic [bfbb_pkg::POS_W-1:0]  n_xmin, n_xmax, n_ymin, n_ymax;
    logic                        r_seen, n_seen;
    logic                        r_ovalid;
    logic                        is_bg, produce;
    logic [7:0]                  a, b, d;
    bfbb_pkg::t_entry            q;

    assign q       = i_q_entry;
    assign produce = q.last || q.err;
    assign o_pop   = i_q_valid && (!produce || !r_ovalid || i_ready);
    assign o_valid = r_ovalid;

    always_comb begin
        n_bg   = q.first ? q.pix : r_bg;
        n_xmin = q.first ? '1 : r_xmin;
        n_xmax = q.first ? '0 : r_xmax;
        n_ymin = q.first ? '1 : r_ymin;
        n_ymax = q.first ? '0 : r_ymax;
        n_seen = q.first ? 1'b0 : r_seen;
        is_bg  = 1'b1;
        a = '0;
        b = '0;
        d = '0;
        for (int s = 0; s < 3; s++) begin
            a = q.pix[8*s +: 8];
            b = n_bg[8*s +: 8];
            d = (a > b) ? a - b : b - a;
            if (d > r_tol) begin
                is_bg = 1'b0;
            end
        end
        if (!is_bg) begin
            if (q.col < n_xmin) n_xmin = q.col;
            if (q.col > n_xmax) n_xmax = q.col;
            if (q.row < n_ymin) n_ymin = q.row;
            if (q.row > n_ymax) n_ymax = q.row;
            n_seen = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= bfbb_pkg::TOL_RESET;
        end else if (i_tolerance_we) begin
            r_tol <= i_tolerance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg   <= '0;
            r_xmin <= '1;
            r_xmax <= '0;
            r_ymin <= '1;
            r_ymax <= '0;
            r_seen <= 1'b0;
        end else if (o_pop && !q.err) begin
            r_bg   <= n_bg;
            r_xmin <= n_xmin;
            r_xmax <= n_xmax;
            r_ymin <= n_ymin;
            r_ymax <= n_ymax;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (o_pop && produce) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && produce) begin
            if (q.err) begin
                o_status           <= 1'b1;
                o_found            <= 1'b0;
                o_x_min            <= '0;
                o_x_max            <= '0;
                o_y_min            <= '0;
                o_y_max            <= '0;
                o_image_width      <= '0;
                o_image_height     <= '0;
                o_background_color <= '0;
            end else begin
                o_status           <= 1'b0;
                o_found            <= n_seen;
                o_x_min            <= n_seen ? n_xmin : '0;
                o_x_max            <= n_seen ? n_xmax : '0;
                o_y_min            <= n_seen ? n_ymin : '0;
                o_y_max            <= n_seen ? n_ymax : '0;
                o_image_width      <= q.width;
                o_image_height     <= q.height;
                o_background_color <= n_bg;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bmp_foreground_bounding_box.sv @@
// The result word for the last pixel byte (or the last header byte of a bad
// header) is written to the queue, then to the back end's output register.
// Throughput: one input byte per cycle while the queue is not full; the 4-word queue absorbs output stalls.
// Reset (synchronous, active low) clears the parser, queue and box, and sets
// tolerance to 10. A start_of_file byte restarts the parse; tolerance is kept.
// Top level: bfbb_front -> bfbb_queue -> bfbb_back. Depends on bfbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp_foreground_bounding_box (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tolerance_we,
    input  wire logic [7:0]                    i_tolerance,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_start_of_file,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_status,
    output logic                               o_found,
    output logic [bfbb_pkg::POS_W-1:0]         o_x_min,
    output logic [bfbb_pkg::POS_W-1:0]         o_x_max,
    output logic [bfbb_pkg::POS_W-1:0]         o_y_min,
    output logic [bfbb_pkg::POS_W-1:0]         o_y_max,
    output logic [bfbb_pkg::DIM_W-1:0]         o_image_width,
    output logic [bfbb_pkg::DIM_W-1:0]         o_image_height,
    output logic [bfbb_pkg::PIX_W-1:0]         o_background_color
);

    logic             push, full, q_valid, pop;
    bfbb_pkg::t_entry push_entry, q_entry;

    bfbb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .i_full          (full),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    bfbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    bfbb_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_tolerance_we     (i_tolerance_we),
        .i_tolerance        (i_tolerance),
        .i_q_valid          (q_valid),
        .i_q_entry          (q_entry),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_found            (o_found),
        .o_x_min            (o_x_min),
        .o_x_max            (o_x_max),
        .o_y_min            (o_y_min),
        .o_y_max            (o_y_max),
        .o_image_width      (o_image_width),
        .o_image_height     (o_image_height),
        .o_background_color (o_background_color)
    );

endmodule

`default_nettype wire

@@ rtl/core/bfbb_checker.sv @@
// Port-level checks for bmp_foreground_bounding_box, bound to the top level.
// Depends on bfbb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfbb_port_sva (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic                          o_status,
    input  wire logic                          o_found,
    input  wire logic [bfbb_pkg::POS_W-1:0]    o_x_min,
    input  wire logic [bfbb_pkg::POS_W-1:0]    o_x_max,
    input  wire logic [bfbb_pkg::POS_W-1:0]    o_y_min,
    input  wire logic [bfbb_pkg::POS_W-1:0]    o_y_max,
    input  wire logic [bfbb_pkg::DIM_W-1:0]    o_image_width,
    input  wire logic [bfbb_pkg::DIM_W-1:0]    o_image_height,
    input  wire logic [bfbb_pkg::PIX_W-1:0]    o_background_color
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_x_min) && $stable(o_status))
        else $error("result word dropped while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_found && o_image_width == '0 &&
            o_image_height == '0 && o_background_color == '0)
        else $error("error word carries data");

    a_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |-> o_image_width != '0 && o_image_height != '0 &&
            o_image_width <= bfbb_pkg::DIM_W'(bfbb_pkg::MAX_DIM) &&
            o_image_height <= bfbb_pkg::DIM_W'(bfbb_pkg::MAX_DIM))
        else $error("ok word with bad dimensions");

    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_x_min <= o_x_max && o_y_min <= o_y_max &&
            {1'b0, o_x_max} < o_image_width && {1'b0, o_y_max} < o_image_height)
        else $error("box out of order or outside image");

    a_empty_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_x_min == '0 && o_x_max == '0 &&
            o_y_min == '0 && o_y_max == '0)
        else $error("empty result with nonzero box");

endmodule

bind bmp_foreground_bounding_box bfbb_port_sva u_bfbb_port_sva (.*);

`default_nettype wire
